### hdl/fpts_pkg.sv
// Shared types and constants for the fixed-priority task scheduler.
// No dependencies; imported by fpts_task_mem, the top level and the testbench.
package fpts_pkg;

   localparam logic [2:0] TASK_NONE = 3'd7;

   localparam logic [1:0] ST_READY    = 2'd0;
   localparam logic [1:0] ST_RUNNING  = 2'd1;
   localparam logic [1:0] ST_BLOCKED  = 2'd2;
   localparam logic [1:0] ST_INACTIVE = 2'd3;

   localparam logic [2:0] ACT_TICK     = 3'd0;
   localparam logic [2:0] ACT_CREATE   = 3'd1;
   localparam logic [2:0] ACT_SEM_WAIT = 3'd2;
   localparam logic [2:0] ACT_SEM_SIG  = 3'd3;
   localparam logic [2:0] ACT_SEM_INIT = 3'd4;

   localparam logic [1:0] CSR_TIME_SLICE  = 2'd0;
   localparam logic [1:0] CSR_SEM_INITIAL = 2'd1;

   localparam logic [2:0]  NORMAL_PRIO    = 3'd3;
   localparam logic [15:0] SLICE_RESET    = 16'd200;
   localparam logic [7:0]  SEM_INIT_RESET = 8'd1;
   localparam logic signed [8:0] SEM_MAX  = 9'sd255;

   typedef struct packed {
      logic       rd_en;
      logic [2:0] rd_addr;
      logic       ent_we;
      logic [2:0] ent_addr;
      logic [2:0] ent_prio;
      logic       link_we;
      logic [2:0] link_addr;
      logic [2:0] link_data;
   } fpts_mem_ctl_type;

endpackage

### hdl/fpts_task_mem.sv
// Per-task tables: priority/run-time memory and queue-link memory, registered read.
// Entries never written read as their reset values via per-entry valid bits. Uses fpts_pkg.
module fpts_task_mem #(
   parameter int NUM_TASKS  = 6,
   parameter int TICK_WIDTH = 16,
   parameter logic [2:0] RESET_PRIO = 3'd3
) (
   input  logic                      clock,
   input  logic                      reset,
   input  fpts_pkg::fpts_mem_ctl_type ctl,
   input  logic [TICK_WIDTH-1:0]     wr_ticks,
   output logic [2:0]                rd_prio,
   output logic [TICK_WIDTH-1:0]     rd_ticks,
   output logic [2:0]                rd_link
);
   import fpts_pkg::*;

   localparam int TIW = $clog2(NUM_TASKS);

   logic [2:0]            prio_mem  [NUM_TASKS];
   logic [TICK_WIDTH-1:0] ticks_mem [NUM_TASKS];
   logic [2:0]            link_mem  [NUM_TASKS];

   logic [NUM_TASKS-1:0]  ent_vld_ff;
   logic [NUM_TASKS-1:0]  link_vld_ff;
   logic [2:0]            prio_rd_ff;
   logic [TICK_WIDTH-1:0] ticks_rd_ff;
   logic [2:0]            link_rd_ff;
   logic                  ent_rv_ff;
   logic                  link_rv_ff;

   logic ent_ok;
   logic link_ok;
   logic rd_ok;

   assign ent_ok  = ctl.ent_we  && (int'(ctl.ent_addr)  < NUM_TASKS);
   assign link_ok = ctl.link_we && (int'(ctl.link_addr) < NUM_TASKS);
   assign rd_ok   = ctl.rd_en   && (int'(ctl.rd_addr)   < NUM_TASKS);

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_vld_ff  <= '0;
         link_vld_ff <= '0;
      end else begin
         if (ent_ok) begin
            ent_vld_ff[ctl.ent_addr[TIW-1:0]] <= 1'b1;
         end
         if (link_ok) begin
            link_vld_ff[ctl.link_addr[TIW-1:0]] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ent_ok) begin
         prio_mem[ctl.ent_addr[TIW-1:0]]  <= ctl.ent_prio;
         ticks_mem[ctl.ent_addr[TIW-1:0]] <= wr_ticks;
      end
      if (link_ok) begin
         link_mem[ctl.link_addr[TIW-1:0]] <= ctl.link_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_ok) begin
         prio_rd_ff  <= prio_mem[ctl.rd_addr[TIW-1:0]];
         ticks_rd_ff <= ticks_mem[ctl.rd_addr[TIW-1:0]];
         link_rd_ff  <= link_mem[ctl.rd_addr[TIW-1:0]];
         ent_rv_ff   <= ent_vld_ff[ctl.rd_addr[TIW-1:0]];
         link_rv_ff  <= link_vld_ff[ctl.rd_addr[TIW-1:0]];
      end
   end

   assign rd_prio  = ent_rv_ff  ? prio_rd_ff  : RESET_PRIO;
   assign rd_ticks = ent_rv_ff  ? ticks_rd_ff : '0;
   assign rd_link  = link_rv_ff ? link_rd_ff  : TASK_NONE;

endmodule

### hdl/fixed_priority_task_scheduler_top.sv
// Fixed-priority preemptive task scheduler with one counting semaphore.
// One request at a time: each accepted request takes two table reads, one
// update, up to three serial link-memory writes and the result register, and
// the next request is accepted only after the block is back in idle. Synchronous
// active-high reset restores all queues, the task tables (per-entry valid bits)
// and the registers at once.
module fixed_priority_task_scheduler_top #(
   parameter int NUM_TASKS      = 6,
   parameter int NUM_PRIORITIES = 6,
   parameter int TICK_WIDTH     = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [2:0]  req_task_priority,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_running_task,
   output logic        rsp_switched,
   output logic        rsp_create_ok,
   output logic [2:0]  rsp_created_task,
   output logic        rsp_caller_blocked,
   output logic        rsp_woken_valid,
   output logic [2:0]  rsp_woken_task,
   output logic signed [8:0] rsp_sem_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import fpts_pkg::*;

   localparam int TIW = $clog2(NUM_TASKS);
   localparam int PW  = $clog2(NUM_PRIORITIES);
   localparam int CW  = (TICK_WIDTH > 16) ? TICK_WIDTH : 16;
   localparam logic [2:0] TOP_PRIO   = 3'(NUM_PRIORITIES - 1);
   localparam logic [2:0] RESET_PRIO =
      (int'(NORMAL_PRIO) < NUM_PRIORITIES) ? NORMAL_PRIO : TOP_PRIO;
   localparam logic [2:0] LAST_TASK = 3'(NUM_TASKS - 1);
   localparam logic signed [8:0] SEM_FLOOR = 9'(-NUM_TASKS);
   localparam logic [TICK_WIDTH-1:0] TICK_MAX = {TICK_WIDTH{1'b1}};

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD0  = 3'd1;
   localparam logic [2:0] S_RD1  = 3'd2;
   localparam logic [2:0] S_EXEC = 3'd3;
   localparam logic [2:0] S_WL   = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [1:0] wl_cnt_ff;

   logic [15:0] slice_ff;
   logic [7:0]  sem_init_ff;

   logic [2:0] act_ff;
   logic [2:0] prio_ff;

   logic [1:0] status_ff [NUM_TASKS];
   logic [1:0] status_in [NUM_TASKS];
   logic [2:0] head_ff [NUM_PRIORITIES];
   logic [2:0] head_in [NUM_PRIORITIES];
   logic [2:0] tail_ff [NUM_PRIORITIES];
   logic [2:0] tail_in [NUM_PRIORITIES];
   logic [2:0] cur_ff, cur_in;
   logic       bp_ff, bp_in;
   logic signed [8:0] sem_ff, sem_in;
   logic [2:0] wh_ff, wh_in;
   logic [2:0] wt_ff, wt_in;

   logic       wl_en_ff   [3];
   logic       wl_en_in   [3];
   logic [2:0] wl_addr_ff [3];
   logic [2:0] wl_addr_in [3];
   logic [2:0] wl_data_ff [3];
   logic [2:0] wl_data_in [3];

   logic [2:0]            e0_prio_ff;
   logic [TICK_WIDTH-1:0] e0_ticks_ff;
   logic [2:0]            e0_link_ff;

   logic       switched_ff, switched_in;
   logic       create_ok_ff, create_ok_in;
   logic [2:0] created_ff, created_in;
   logic       blocked_ff, blocked_in;
   logic       woken_v_ff, woken_v_in;
   logic [2:0] woken_ff, woken_in;

   logic       rsp_valid_ff;
   logic [2:0] rsp_running_ff;
   logic       rsp_switched_ff;
   logic       rsp_create_ok_ff;
   logic [2:0] rsp_created_ff;
   logic       rsp_blocked_ff;
   logic       rsp_woken_v_ff;
   logic [2:0] rsp_woken_ff;
   logic signed [8:0] rsp_sem_ff;

   fpts_mem_ctl_type      mem_ctl;
   logic [TICK_WIDTH-1:0] mem_wr_ticks;
   logic [2:0]            mem_rd_prio;
   logic [TICK_WIDTH-1:0] mem_rd_ticks;
   logic [2:0]            mem_rd_link;

   logic [2:0] nxt;
   logic [2:0] addr0;
   logic       ent_we_v;
   logic [2:0] ent_addr_v;
   logic [2:0] ent_prio_v;
   logic [TICK_WIDTH-1:0] ent_ticks_v;
   logic       req_take;
   logic       rsp_free;

   fpts_task_mem #(
      .NUM_TASKS  (NUM_TASKS),
      .TICK_WIDTH (TICK_WIDTH),
      .RESET_PRIO (RESET_PRIO)
   ) u_task_mem (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mem_ctl),
      .wr_ticks (mem_wr_ticks),
      .rd_prio  (mem_rd_prio),
      .rd_ticks (mem_rd_ticks),
      .rd_link  (mem_rd_link)
   );

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      nxt = cur_ff;
      for (int p = 0; p < NUM_PRIORITIES; p++) begin
         if (int'(head_ff[p]) < NUM_TASKS) begin
            nxt = head_ff[p];
         end
      end
   end

   assign addr0 = (act_ff == ACT_TICK) ? cur_ff : wh_ff;

   always_comb begin
      mem_ctl           = '0;
      mem_ctl.rd_en     = (state_ff == S_RD0) || (state_ff == S_RD1);
      mem_ctl.rd_addr   = (state_ff == S_RD0) ? addr0 : nxt;
      mem_ctl.ent_we    = (state_ff == S_EXEC) && ent_we_v;
      mem_ctl.ent_addr  = ent_addr_v;
      mem_ctl.ent_prio  = ent_prio_v;
      mem_ctl.link_we   = (state_ff == S_WL) && wl_en_ff[wl_cnt_ff];
      mem_ctl.link_addr = wl_addr_ff[wl_cnt_ff];
      mem_ctl.link_data = wl_data_ff[wl_cnt_ff];
      mem_wr_ticks      = ent_ticks_v;
   end

   always_comb begin
      logic [TICK_WIDTH-1:0] tick_new;
      logic       do_push;
      logic [2:0] push_t;
      logic [2:0] push_p;
      logic       do_run;
      logic [2:0] link_nxt;
      logic       found;
      logic [2:0] w;

      for (int i = 0; i < NUM_TASKS; i++) begin
         status_in[i] = status_ff[i];
      end
      for (int p = 0; p < NUM_PRIORITIES; p++) begin
         head_in[p] = head_ff[p];
         tail_in[p] = tail_ff[p];
      end
      for (int k = 0; k < 3; k++) begin
         wl_en_in[k]   = 1'b0;
         wl_addr_in[k] = TASK_NONE;
         wl_data_in[k] = TASK_NONE;
      end
      cur_in       = cur_ff;
      bp_in        = bp_ff;
      sem_in       = sem_ff;
      wh_in        = wh_ff;
      wt_in        = wt_ff;
      ent_we_v     = 1'b0;
      ent_addr_v   = cur_ff;
      ent_prio_v   = e0_prio_ff;
      ent_ticks_v  = '0;
      switched_in  = 1'b0;
      create_ok_in = 1'b0;
      created_in   = 3'd0;
      blocked_in   = 1'b0;
      woken_v_in   = 1'b0;
      woken_in     = 3'd0;
      tick_new     = (e0_ticks_ff == TICK_MAX) ? e0_ticks_ff : e0_ticks_ff + 1'b1;
      do_push      = 1'b0;
      push_t       = cur_ff;
      push_p       = e0_prio_ff;
      do_run       = 1'b0;
      found        = 1'b0;
      w            = wh_ff;

      case (act_ff)
         ACT_TICK: begin
            ent_we_v    = 1'b1;
            ent_ticks_v = tick_new;
            if (bp_ff) begin
               if (nxt != cur_ff) begin
                  ent_ticks_v = '0;
                  do_run      = 1'b1;
                  bp_in       = 1'b0;
               end
            end else if (e0_prio_ff < mem_rd_prio) begin
               ent_ticks_v = '0;
               do_push     = 1'b1;
               do_run      = 1'b1;
            end else if (CW'(tick_new) >= CW'(slice_ff)) begin
               ent_ticks_v = '0;
               if (nxt != cur_ff && mem_rd_prio >= e0_prio_ff) begin
                  do_push = 1'b1;
                  do_run  = 1'b1;
               end
            end
         end
         ACT_CREATE: begin
            for (int i = NUM_TASKS - 1; i >= 0; i--) begin
               if (status_ff[i] == ST_INACTIVE) begin
                  found  = 1'b1;
                  push_t = 3'(i);
               end
            end
            if (found) begin
               ent_we_v     = 1'b1;
               ent_addr_v   = push_t;
               ent_prio_v   = prio_ff;
               ent_ticks_v  = '0;
               push_p       = prio_ff;
               do_push      = 1'b1;
               create_ok_in = 1'b1;
               created_in   = push_t;
            end
         end
         ACT_SEM_WAIT: begin
            if (!bp_ff && sem_ff > SEM_FLOOR) begin
               sem_in = sem_ff - 9'sd1;
               if (sem_in < 0) begin
                  wl_en_in[0]   = 1'b1;
                  wl_addr_in[0] = cur_ff;
                  wl_data_in[0] = TASK_NONE;
                  if (wh_ff == TASK_NONE || int'(wt_ff) >= NUM_TASKS) begin
                     wh_in = cur_ff;
                  end else begin
                     wl_en_in[1]   = 1'b1;
                     wl_addr_in[1] = wt_ff;
                     wl_data_in[1] = cur_ff;
                  end
                  wt_in = cur_ff;
                  status_in[cur_ff[TIW-1:0]] = ST_BLOCKED;
                  bp_in      = 1'b1;
                  blocked_in = 1'b1;
               end
            end
         end
         ACT_SEM_SIG: begin
            if (sem_ff < SEM_MAX) begin
               sem_in = sem_ff + 9'sd1;
            end
            if (sem_in <= 0 && int'(wh_ff) < NUM_TASKS) begin
               wh_in = e0_link_ff;
               if (e0_link_ff == TASK_NONE) begin
                  wt_in = TASK_NONE;
               end
               wl_en_in[0]   = 1'b1;
               wl_addr_in[0] = w;
               wl_data_in[0] = TASK_NONE;
               if (w == cur_ff && bp_ff) begin
                  bp_in = 1'b0;
                  status_in[w[TIW-1:0]] = ST_RUNNING;
               end else begin
                  do_push = 1'b1;
                  push_t  = w;
                  push_p  = e0_prio_ff;
               end
               woken_v_in = 1'b1;
               woken_in   = w;
            end
         end
         ACT_SEM_INIT: begin
            sem_in = $signed({1'b0, sem_init_ff});
         end
         default: begin
         end
      endcase

      if (do_push) begin
         status_in[push_t[TIW-1:0]] = ST_READY;
         wl_en_in[0]   = 1'b1;
         wl_addr_in[0] = push_t;
         wl_data_in[0] = TASK_NONE;
         if (head_in[push_p[PW-1:0]] == TASK_NONE ||
             int'(tail_in[push_p[PW-1:0]]) >= NUM_TASKS) begin
            head_in[push_p[PW-1:0]] = push_t;
         end else begin
            wl_en_in[1]   = 1'b1;
            wl_addr_in[1] = tail_in[push_p[PW-1:0]];
            wl_data_in[1] = push_t;
         end
         tail_in[push_p[PW-1:0]] = push_t;
      end

      link_nxt = (wl_en_in[1] && wl_addr_in[1] == nxt) ? wl_data_in[1] : mem_rd_link;
      if (do_run) begin
         if (head_in[mem_rd_prio[PW-1:0]] == nxt) begin
            head_in[mem_rd_prio[PW-1:0]] = link_nxt;
            if (link_nxt == TASK_NONE) begin
               tail_in[mem_rd_prio[PW-1:0]] = TASK_NONE;
            end
         end
         wl_en_in[2]   = 1'b1;
         wl_addr_in[2] = nxt;
         wl_data_in[2] = TASK_NONE;
         status_in[nxt[TIW-1:0]] = ST_RUNNING;
         cur_in      = nxt;
         switched_in = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_RD0;
            end
         end
         S_RD0:  state_in = S_RD1;
         S_RD1:  state_in = S_EXEC;
         S_EXEC: state_in = S_WL;
         S_WL: begin
            if (wl_cnt_ff == 2'd2) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         wl_cnt_ff   <= 2'd0;
         slice_ff    <= SLICE_RESET;
         sem_init_ff <= SEM_INIT_RESET;
         for (int i = 0; i < NUM_TASKS; i++) begin
            status_ff[i] <= (i == NUM_TASKS - 1) ? ST_RUNNING : ST_INACTIVE;
         end
         for (int p = 0; p < NUM_PRIORITIES; p++) begin
            head_ff[p] <= TASK_NONE;
            tail_ff[p] <= TASK_NONE;
         end
         cur_ff       <= LAST_TASK;
         bp_ff        <= 1'b0;
         sem_ff       <= '0;
         wh_ff        <= TASK_NONE;
         wt_ff        <= TASK_NONE;
         for (int k = 0; k < 3; k++) begin
            wl_en_ff[k] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TIME_SLICE:  slice_ff    <= csr_wdata;
               CSR_SEM_INITIAL: sem_init_ff <= csr_wdata[7:0];
               default: begin
               end
            endcase
         end
         if (state_ff == S_EXEC) begin
            wl_cnt_ff <= 2'd0;
            for (int i = 0; i < NUM_TASKS; i++) begin
               status_ff[i] <= status_in[i];
            end
            for (int p = 0; p < NUM_PRIORITIES; p++) begin
               head_ff[p] <= head_in[p];
               tail_ff[p] <= tail_in[p];
            end
            cur_ff <= cur_in;
            bp_ff  <= bp_in;
            sem_ff <= sem_in;
            wh_ff  <= wh_in;
            wt_ff  <= wt_in;
            for (int k = 0; k < 3; k++) begin
               wl_en_ff[k] <= wl_en_in[k];
            end
         end else if (state_ff == S_WL) begin
            wl_cnt_ff <= wl_cnt_ff + 2'd1;
         end
         if (state_ff == S_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         act_ff  <= req_action;
         prio_ff <= (int'(req_task_priority) < NUM_PRIORITIES) ? req_task_priority
                                                                : TOP_PRIO;
      end
      if (state_ff == S_RD1) begin
         e0_prio_ff  <= mem_rd_prio;
         e0_ticks_ff <= mem_rd_ticks;
         e0_link_ff  <= mem_rd_link;
      end
      if (state_ff == S_EXEC) begin
         for (int k = 0; k < 3; k++) begin
            wl_addr_ff[k] <= wl_addr_in[k];
            wl_data_ff[k] <= wl_data_in[k];
         end
         switched_ff  <= switched_in;
         create_ok_ff <= create_ok_in;
         created_ff   <= created_in;
         blocked_ff   <= blocked_in;
         woken_v_ff   <= woken_v_in;
         woken_ff     <= woken_in;
      end
      if (state_ff == S_DONE && rsp_free) begin
         rsp_running_ff   <= cur_ff;
         rsp_switched_ff  <= switched_ff;
         rsp_create_ok_ff <= create_ok_ff;
         rsp_created_ff   <= created_ff;
         rsp_blocked_ff   <= blocked_ff;
         rsp_woken_v_ff   <= woken_v_ff;
         rsp_woken_ff     <= woken_ff;
         rsp_sem_ff       <= sem_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_running_task   = rsp_running_ff;
   assign rsp_switched       = rsp_switched_ff;
   assign rsp_create_ok      = rsp_create_ok_ff;
   assign rsp_created_task   = rsp_created_ff;
   assign rsp_caller_blocked = rsp_blocked_ff;
   assign rsp_woken_valid    = rsp_woken_v_ff;
   assign rsp_woken_task     = rsp_woken_ff;
   assign rsp_sem_value      = rsp_sem_ff;

`ifndef SYNTHESIS
   a_cur_running: assert property (@(posedge clock) disable iff (reset)
      !bp_ff |-> status_ff[cur_ff[TIW-1:0]] == ST_RUNNING)
      else $error("current task not running without pending block");

   a_cur_blocked: assert property (@(posedge clock) disable iff (reset)
      bp_ff |-> status_ff[cur_ff[TIW-1:0]] == ST_BLOCKED)
      else $error("pending block but current task not blocked");

   a_sem_range: assert property (@(posedge clock) disable iff (reset)
      sem_ff >= SEM_FLOOR && sem_ff <= SEM_MAX)
      else $error("semaphore count out of range");

   a_wait_empty: assert property (@(posedge clock) disable iff (reset)
      (wh_ff == TASK_NONE) |-> (sem_ff >= 0))
      else $error("negative count with empty wait queue");
`endif

endmodule

### tb/tb_fixed_priority_task_scheduler_top.sv
// Self-checking testbench for fixed_priority_task_scheduler_top.
// Keeps its own scheduler and semaphore state, predicts each result beat and
// checks it field by field; depends on fpts_pkg and the top level only.
module tb_fixed_priority_task_scheduler_top;
   import fpts_pkg::*;

   localparam int NTASK = 6;
   localparam int NPRIO = 6;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic [2:0] running_task;
      logic       switched;
      logic       create_ok;
      logic [2:0] created_task;
      logic       caller_blocked;
      logic       woken_valid;
      logic [2:0] woken_task;
      logic [8:0] sem_value;
   } sched_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_action = '0;
   logic [2:0]  req_task_priority = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_running_task;
   logic        rsp_switched;
   logic        rsp_create_ok;
   logic [2:0]  rsp_created_task;
   logic        rsp_caller_blocked;
   logic        rsp_woken_valid;
   logic [2:0]  rsp_woken_task;
   logic signed [8:0] rsp_sem_value;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   fixed_priority_task_scheduler_top dut (.*);

   always #10 clock = ~clock;

   // scheduler shadow state
   logic [1:0]  t_status [NTASK];
   logic [2:0]  t_prio [NTASK];
   logic [15:0] t_ticks [NTASK];
   logic [2:0]  t_link [NTASK];
   logic [2:0]  rq_head [NPRIO];
   logic [2:0]  rq_tail [NPRIO];
   logic [2:0]  cur_task;
   logic        blk_pending;
   int          sem_cnt;
   logic [2:0]  wq_head, wq_tail;
   logic [15:0] slice_reg;
   logic [7:0]  sem_init_reg;

   sched_rsp_type rsp_expect_q[$];
   int          mismatches = 0;
   int          cycles = 0;

   function automatic logic [2:0] clamp_prio(logic [2:0] p);
      return (p < NPRIO) ? p : 3'(NPRIO - 1);
   endfunction

   function automatic void sched_reset();
      for (int i = 0; i < NTASK; i++) begin
         t_status[i] = ST_INACTIVE;
         t_prio[i] = clamp_prio(NORMAL_PRIO);
         t_ticks[i] = '0;
         t_link[i] = TASK_NONE;
      end
      for (int i = 0; i < NPRIO; i++) begin
         rq_head[i] = TASK_NONE;
         rq_tail[i] = TASK_NONE;
      end
      cur_task = 3'(NTASK - 1);
      t_status[NTASK - 1] = ST_RUNNING;
      blk_pending = 1'b0;
      sem_cnt = 0;
      wq_head = TASK_NONE;
      wq_tail = TASK_NONE;
      slice_reg = SLICE_RESET;
      sem_init_reg = SEM_INIT_RESET;
   endfunction

   function automatic void ready_append(logic [2:0] t);
      logic [2:0] p;
      p = clamp_prio(t_prio[t]);
      t_status[t] = ST_READY;
      t_link[t] = TASK_NONE;
      if (rq_head[p] == TASK_NONE || rq_tail[p] >= NTASK) rq_head[p] = t;
      else t_link[rq_tail[p]] = t;
      rq_tail[p] = t;
   endfunction

   function automatic void dispatch(logic [2:0] t);
      logic [2:0] p;
      p = clamp_prio(t_prio[t]);
      if (rq_head[p] == t) begin
         rq_head[p] = t_link[t];
         if (rq_head[p] == TASK_NONE) rq_tail[p] = TASK_NONE;
      end
      t_link[t] = TASK_NONE;
      t_status[t] = ST_RUNNING;
      cur_task = t;
   endfunction

   function automatic logic [2:0] best_ready();
      for (int p = NPRIO - 1; p >= 0; p--)
         if (rq_head[p] < NTASK) return rq_head[p];
      return cur_task;
   endfunction

   function automatic logic tick_sched();
      logic [2:0] c, n;
      c = (cur_task < NTASK) ? cur_task : 3'(NTASK - 1);
      if (t_ticks[c] != 16'hFFFF) t_ticks[c] = t_ticks[c] + 16'd1;
      n = best_ready();
      if (blk_pending) begin
         if (n == c) return 1'b0;
         t_ticks[c] = '0;
         dispatch(n);
         blk_pending = 1'b0;
         return 1'b1;
      end
      if (t_prio[c] < t_prio[n]) begin
         t_ticks[c] = '0;
         ready_append(c);
         dispatch(n);
         return 1'b1;
      end
      if (t_ticks[c] >= slice_reg) begin
         t_ticks[c] = '0;
         if (n != c && t_prio[n] >= t_prio[c]) begin
            ready_append(c);
            dispatch(n);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic sched_rsp_type sched_apply(logic [2:0] act, logic [2:0] prio_in);
      sched_rsp_type r;
      logic [2:0] c, p, w;
      r = '0;
      p = clamp_prio(prio_in);
      c = (cur_task < NTASK) ? cur_task : 3'(NTASK - 1);
      case (act)
         ACT_TICK: r.switched = tick_sched();
         ACT_CREATE: begin
            for (int i = 0; i < NTASK; i++) begin
               if (!r.create_ok && t_status[i] == ST_INACTIVE) begin
                  t_prio[i] = p;
                  t_ticks[i] = '0;
                  ready_append(3'(i));
                  r.create_ok = 1'b1;
                  r.created_task = 3'(i);
               end
            end
         end
         ACT_SEM_WAIT: begin
            if (!blk_pending && sem_cnt > -NTASK) begin
               sem_cnt--;
               if (sem_cnt < 0) begin
                  t_link[c] = TASK_NONE;
                  if (wq_head == TASK_NONE || wq_tail >= NTASK) wq_head = c;
                  else t_link[wq_tail] = c;
                  wq_tail = c;
                  t_status[c] = ST_BLOCKED;
                  blk_pending = 1'b1;
                  r.caller_blocked = 1'b1;
               end
            end
         end
         ACT_SEM_SIG: begin
            if (sem_cnt < 255) sem_cnt++;
            if (sem_cnt <= 0 && wq_head < NTASK) begin
               w = wq_head;
               wq_head = t_link[w];
               if (wq_head == TASK_NONE) wq_tail = TASK_NONE;
               t_link[w] = TASK_NONE;
               if (w == c && blk_pending) begin
                  blk_pending = 1'b0;
                  t_status[w] = ST_RUNNING;
               end else begin
                  ready_append(w);
               end
               r.woken_valid = 1'b1;
               r.woken_task = w;
            end
         end
         ACT_SEM_INIT: sem_cnt = int'(sem_init_reg);
         default: ;
      endcase
      r.running_task = cur_task;
      r.sem_value = sem_cnt[8:0];
      return r;
   endfunction

   // stimulus side
   task automatic send_item(logic [2:0] act, logic [2:0] prio);
      logic ok;
      int gap;
      req_valid <= 1'b1;
      req_action <= act;
      req_task_priority <= prio;
      ok = 1'b0;
      while (!ok) begin
         @(negedge clock);
         ok = !req_stall;
         @(posedge clock);
      end
      rsp_expect_q.push_back(sched_apply(act, prio));
      case ($urandom_range(0, 9))
         0, 1, 2, 3: gap = 0;
         4, 5, 6, 7, 8: gap = $urandom_range(1, 4);
         default: gap = $urandom_range(10, 40);
      endcase
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (rsp_expect_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [15:0] data);
      logic ok;
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      ok = 1'b0;
      while (!ok) begin
         @(negedge clock);
         ok = csr_ready;
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      if (idx == CSR_TIME_SLICE) slice_reg = data;
      else if (idx == CSR_SEM_INITIAL) sem_init_reg = data[7:0];
   endtask

   task automatic test_directed_create();
      for (int p = 0; p < 8; p++) send_item(ACT_CREATE, 3'(p));
      for (int a = 5; a < 8; a++) send_item(3'(a), 3'(7 - a));
   endtask

   task automatic test_directed_semaphore();
      csr_write(CSR_SEM_INITIAL, 16'd0);
      send_item(ACT_SEM_INIT, 3'd0);
      send_item(ACT_SEM_WAIT, 3'd0);
      send_item(ACT_SEM_WAIT, 3'd0);
      send_item(ACT_SEM_SIG, 3'd0);
      send_item(ACT_SEM_WAIT, 3'd0);
      send_item(ACT_TICK, 3'd0);
      send_item(ACT_SEM_WAIT, 3'd0);
      send_item(ACT_SEM_SIG, 3'd0);
      send_item(ACT_SEM_SIG, 3'd0);
      csr_write(CSR_SEM_INITIAL, 16'hFFFF);
      send_item(ACT_SEM_INIT, 3'd0);
      send_item(ACT_SEM_SIG, 3'd0);
   endtask

   task automatic test_directed_slice();
      csr_write(CSR_TIME_SLICE, 16'd0);
      repeat (4) send_item(ACT_TICK, 3'd0);
   endtask

   task automatic test_random(logic [15:0] slice, logic [7:0] sinit, int count);
      logic [2:0] act;
      csr_write(CSR_TIME_SLICE, slice);
      csr_write(CSR_SEM_INITIAL, {8'd0, sinit});
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 99)) inside
            [0:44]:  act = ACT_TICK;
            [45:54]: act = ACT_CREATE;
            [55:69]: act = ACT_SEM_WAIT;
            [70:86]: act = ACT_SEM_SIG;
            [87:93]: act = ACT_SEM_INIT;
            default: act = 3'($urandom_range(5, 7));
         endcase
         send_item(act, 3'($urandom_range(0, 7)));
      end
   endtask

   // result side
   always @(posedge clock) begin
      if ($urandom_range(0, 29) == 0) rsp_stall <= 1'b1;
      else if (rsp_stall && $urandom_range(0, 3) == 0) rsp_stall <= 1'b0;
      else if (!rsp_stall) rsp_stall <= ($urandom_range(0, 5) == 0);
   end

   function automatic void field_check(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %s: expected %0d actual %0d", name, exp_v, act_v);
      end
   endfunction

   always @(negedge clock) begin
      sched_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_expect_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: result beat with nothing expected");
         end else begin
            e = rsp_expect_q.pop_front();
            field_check("running_task", e.running_task, rsp_running_task);
            field_check("switched", e.switched, rsp_switched);
            field_check("create_ok", e.create_ok, rsp_create_ok);
            field_check("created_task", e.created_task, rsp_created_task);
            field_check("caller_blocked", e.caller_blocked, rsp_caller_blocked);
            field_check("woken_valid", e.woken_valid, rsp_woken_valid);
            field_check("woken_task", e.woken_task, rsp_woken_task);
            field_check("sem_value", $signed(e.sem_value), rsp_sem_value);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      sched_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_create();
      test_directed_semaphore();
      test_directed_slice();
      test_random(16'd1, 8'd0, 150);
      test_random(16'd3, 8'd2, 150);
      test_random(16'd0, 8'd255, 150);
      test_random(16'hFFFF, 8'd1, 150);
      test_random(16'($urandom_range(2, 8)), 8'($urandom_range(0, 255)), 150);
      drain();
      if (mismatches == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
